/* design/json_key_value_locator_macros.svh */
// ----------------------------------------------------------------------------
// json key/value locator assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_LOCATOR_MACROS_SVH
`define JSON_KEY_VALUE_LOCATOR_MACROS_SVH

// property that must hold at every edge out of reset
`define JKVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define JKVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/jkvl_pkg.sv */
// ----------------------------------------------------------------------------
// jkvl_pkg
// shared types, constants and helpers of the json key/value locator
// ----------------------------------------------------------------------------
package jkvl_pkg;

  localparam int unsigned MaxKeyBytes = 8;
  localparam int unsigned PosBits     = 16;
  localparam int unsigned DepthBits   = 8;
  localparam int unsigned KeyLenBits  = 4;
  localparam int unsigned KeyBits     = 8 * MaxKeyBytes;
  localparam int unsigned CfgBits     = 64;

  typedef logic [PosBits-1:0]    pos_t;
  typedef logic [DepthBits-1:0]  depth_t;
  typedef logic [KeyLenBits-1:0] klen_t;

  localparam pos_t   PosMax      = {PosBits{1'b1}};
  localparam depth_t MaxDepth    = 8'd255;
  localparam klen_t  KeyLenLimit = 4'd8;

  // configuration register indexes
  localparam logic CfgKeyText   = 1'b0;
  localparam logic CfgKeyLength = 1'b1;

  // character codes
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChLBrace  = 8'h7b;
  localparam logic [7:0] ChRBrace  = 8'h7d;
  localparam logic [7:0] ChLBrack  = 8'h5b;
  localparam logic [7:0] ChRBrack  = 8'h5d;
  localparam logic [7:0] ChBslash  = 8'h5c;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_MATCH  = 7'b0000010,
    PH_COLON  = 7'b0000100,
    PH_LEAD   = 7'b0001000,
    PH_SCAN   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_DRAIN  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic found;
    pos_t value_offset;
    pos_t value_length;
    logic overflow;
  } res_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

endpackage

/* design/jkvl_if.sv */
// ----------------------------------------------------------------------------
// jkvl channel interfaces
// valid/ready channels for document bytes and located values
// ----------------------------------------------------------------------------
interface jkvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface jkvl_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  jkvl_pkg::pos_t    value_offset;
  jkvl_pkg::pos_t    value_length;
  logic              overflow;

  modport source (output valid, output found, output value_offset, output value_length,
                  output overflow, input ready);
  modport sink   (input valid, input found, input value_offset, input value_length,
                  input overflow, output ready);
endinterface

/* design/json_key_value_locator.sv */
// Path: an accepted byte waits in the input register until the parser takes it, and
//   a document's result is loaded into the output register at that same parser update.
// Throughput: one byte per cycle; the input register stalls only while a result
//   waits in the output register and the output side is not ready.
// Reset: asynchronous, clears key registers, parser state and both valid flags.
// ----------------------------------------------------------------------------
// json_key_value_locator
// streams a json document and reports where the configured key's value sits
// ----------------------------------------------------------------------------
`include "json_key_value_locator_macros.svh"

module json_key_value_locator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [jkvl_pkg::CfgBits-1:0]  cfg_wdata_i,
  jkvl_in_if.sink                       in_i,
  jkvl_out_if.source                    out_o
);

  logic [jkvl_pkg::KeyBits-1:0] key_text_q;
  jkvl_pkg::klen_t              key_len_q;
  logic                         in_vld_q, in_vld_d;
  logic [7:0]                   byte_q;
  logic                         last_q;
  logic                         out_free, advance, accept, emit;
  jkvl_pkg::res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q <= '0;
      key_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jkvl_pkg::CfgKeyText:   key_text_q <= cfg_wdata_i[jkvl_pkg::KeyBits-1:0];
        jkvl_pkg::CfgKeyLength: key_len_q  <= cfg_wdata_i[jkvl_pkg::KeyLenBits-1:0];
        default: ;
      endcase
    end
  end

  // input register: one transaction held until the parser consumes it
  assign out_free   = ~out_o.valid | out_o.ready;
  assign advance    = in_vld_q & out_free;
  assign in_i.ready = ~in_vld_q | out_free;
  assign accept     = in_i.valid & in_i.ready;
  assign in_vld_d   = accept | (in_vld_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else in_vld_q <= in_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.byte_value;
      last_q <= in_i.last_byte;
    end
  end

  jkvl_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (advance),
    .byte_i     (byte_q),
    .last_i     (last_q),
    .key_text_i (key_text_q),
    .key_len_i  (key_len_q),
    .emit_o     (emit),
    .res_o      (res)
  );

  jkvl_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance & emit),
    .res_i  (res),
    .out_o  (out_o)
  );

  `JKVL_ASSERT(a_ready_only_on_stall, !in_i.ready |-> (in_vld_q && out_o.valid && !out_o.ready), "input stalled without a held result")
  `JKVL_ASSERT_NEXT(a_emit_loads, advance && emit, out_o.valid, "emitted result not presented")
  `JKVL_ASSERT(a_notfound_zero, (out_o.valid && !out_o.found) |-> (out_o.value_offset == '0 && out_o.value_length == '0), "missing key with nonzero span")

endmodule

/* design/jkvl_parser.sv */
// ----------------------------------------------------------------------------
// jkvl_parser
// per-byte key match, colon and value scan state with result formation
// ----------------------------------------------------------------------------
module jkvl_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  input  logic [jkvl_pkg::KeyBits-1:0] key_text_i,
  input  jkvl_pkg::klen_t         key_len_i,
  output logic                    emit_o,
  output jkvl_pkg::res_t          res_o
);

  jkvl_pkg::phase_e ph_q, ph_d, t_ph;
  jkvl_pkg::klen_t  mi_q, mi_d, t_mi, klen;
  jkvl_pkg::pos_t   pos_q, pos_d, t_pos;
  jkvl_pkg::pos_t   start_q, start_d, t_start;
  jkvl_pkg::pos_t   cend_q, cend_d, t_cend;
  jkvl_pkg::depth_t depth_q, depth_d, t_depth;
  logic             instr_q, instr_d, t_instr;
  logic             esc_q, esc_d, t_esc;
  logic             sat_q, sat_d, t_sat;
  logic             do_scan, mark;
  logic [7:0]       key_byte;

  function automatic jkvl_pkg::res_t make_res(jkvl_pkg::phase_e ph, jkvl_pkg::pos_t pos,
                                             jkvl_pkg::pos_t st, jkvl_pkg::pos_t ce,
                                             logic sat);
    jkvl_pkg::res_t r;
    jkvl_pkg::pos_t s;
    jkvl_pkg::pos_t e;
    r.found = (ph == jkvl_pkg::PH_LEAD) || (ph == jkvl_pkg::PH_SCAN) ||
              (ph == jkvl_pkg::PH_DONE);
    s = '0;
    e = '0;
    if (ph == jkvl_pkg::PH_LEAD) begin
      s = pos;
      e = pos;
    end else if (r.found) begin
      s = st;
      e = ce;
    end
    r.value_offset = s;
    r.value_length = (e >= s) ? e - s : '0;
    r.overflow     = sat;
    return r;
  endfunction

  assign klen     = (key_len_i > jkvl_pkg::KeyLenLimit) ? jkvl_pkg::KeyLenLimit : key_len_i;
  assign key_byte = key_text_i[{mi_q[2:0], 3'b000} +: 8];

  // effect of one nonzero byte
  always_comb begin
    t_ph    = ph_q;
    t_mi    = mi_q;
    t_pos   = pos_q;
    t_start = start_q;
    t_cend  = cend_q;
    t_depth = depth_q;
    t_instr = instr_q;
    t_esc   = esc_q;
    t_sat   = sat_q;
    do_scan = 1'b0;
    mark    = 1'b0;
    case (ph_q)
      jkvl_pkg::PH_SEARCH: begin
        if (byte_i == jkvl_pkg::ChQuote) begin
          t_ph = jkvl_pkg::PH_MATCH;
          t_mi = '0;
        end
      end
      jkvl_pkg::PH_MATCH: begin
        if (byte_i == jkvl_pkg::ChQuote) begin
          if (mi_q == klen) t_ph = jkvl_pkg::PH_COLON;
          else t_mi = '0;
        end else if ((mi_q < klen) && (byte_i == key_byte)) begin
          t_mi = mi_q + 4'd1;
        end else begin
          t_ph = jkvl_pkg::PH_SEARCH;
        end
      end
      jkvl_pkg::PH_COLON: begin
        if (!jkvl_pkg::is_space(byte_i)) begin
          if (byte_i == jkvl_pkg::ChColon) begin
            t_ph = jkvl_pkg::PH_LEAD;
          end else if (byte_i == jkvl_pkg::ChQuote) begin
            t_ph = jkvl_pkg::PH_MATCH;
            t_mi = '0;
          end else begin
            t_ph = jkvl_pkg::PH_SEARCH;
          end
        end
      end
      jkvl_pkg::PH_LEAD: begin
        if (!jkvl_pkg::is_space(byte_i)) begin
          t_start = pos_q;
          t_cend  = pos_q;
          t_ph    = jkvl_pkg::PH_SCAN;
          do_scan = 1'b1;
        end
      end
      jkvl_pkg::PH_SCAN: do_scan = 1'b1;
      default: ;
    endcase

    if (do_scan) begin
      if (instr_q) begin
        if (esc_q) t_esc = 1'b0;
        else if (byte_i == jkvl_pkg::ChBslash) t_esc = 1'b1;
        else if (byte_i == jkvl_pkg::ChQuote) t_instr = 1'b0;
        mark = 1'b1;
      end else if (byte_i == jkvl_pkg::ChQuote) begin
        t_instr = 1'b1;
        mark    = 1'b1;
      end else if ((byte_i == jkvl_pkg::ChLBrace) || (byte_i == jkvl_pkg::ChLBrack)) begin
        if (depth_q >= jkvl_pkg::MaxDepth) t_sat = 1'b1;
        else t_depth = depth_q + 8'd1;
        mark = 1'b1;
      end else if ((byte_i == jkvl_pkg::ChRBrace) || (byte_i == jkvl_pkg::ChRBrack)) begin
        // closer at depth zero ends the value
        if (depth_q == '0) begin
          t_ph = jkvl_pkg::PH_DONE;
        end else begin
          t_depth = depth_q - 8'd1;
          mark    = 1'b1;
        end
      end else if ((byte_i == jkvl_pkg::ChComma) && (depth_q == '0)) begin
        t_ph = jkvl_pkg::PH_DONE;
      end else begin
        mark = 1'b1;
      end
      if (mark && !jkvl_pkg::is_space(byte_i)) begin
        if (pos_q == jkvl_pkg::PosMax) begin
          t_cend = jkvl_pkg::PosMax;
          t_sat  = 1'b1;
        end else begin
          t_cend = pos_q + 16'd1;
        end
      end
    end

    if (pos_q == jkvl_pkg::PosMax) t_sat = 1'b1;
    else t_pos = pos_q + 16'd1;
  end

  // document boundaries: zero byte, last byte and drain after a zero byte
  always_comb begin
    ph_d    = t_ph;
    mi_d    = t_mi;
    pos_d   = t_pos;
    start_d = t_start;
    cend_d  = t_cend;
    depth_d = t_depth;
    instr_d = t_instr;
    esc_d   = t_esc;
    sat_d   = t_sat;
    emit_o  = 1'b0;
    res_o   = make_res(t_ph, t_pos, t_start, t_cend, t_sat);
    if ((ph_q == jkvl_pkg::PH_DRAIN) || (byte_i == jkvl_pkg::ChNul) || last_i) begin
      ph_d    = jkvl_pkg::PH_SEARCH;
      mi_d    = '0;
      pos_d   = '0;
      start_d = '0;
      cend_d  = '0;
      depth_d = '0;
      instr_d = 1'b0;
      esc_d   = 1'b0;
      sat_d   = 1'b0;
    end
    if (ph_q == jkvl_pkg::PH_DRAIN) begin
      if (!last_i) ph_d = jkvl_pkg::PH_DRAIN;
    end else if (byte_i == jkvl_pkg::ChNul) begin
      emit_o = 1'b1;
      res_o  = make_res(ph_q, pos_q, start_q, cend_q, sat_q);
      if (!last_i) ph_d = jkvl_pkg::PH_DRAIN;
    end else if (last_i) begin
      emit_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= jkvl_pkg::PH_SEARCH;
      mi_q    <= '0;
      pos_q   <= '0;
      start_q <= '0;
      cend_q  <= '0;
      depth_q <= '0;
      instr_q <= 1'b0;
      esc_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else if (adv_i) begin
      ph_q    <= ph_d;
      mi_q    <= mi_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      cend_q  <= cend_d;
      depth_q <= depth_d;
      instr_q <= instr_d;
      esc_q   <= esc_d;
      sat_q   <= sat_d;
    end
  end

endmodule

/* design/jkvl_out_reg.sv */
// ----------------------------------------------------------------------------
// jkvl_out_reg
// result register driving the output channel
// ----------------------------------------------------------------------------
module jkvl_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  jkvl_pkg::res_t res_i,
  jkvl_out_if.source     out_o
);

  logic           vld_q, vld_d;
  jkvl_pkg::res_t res_q;

  // load is only issued when the register is empty or being drained
  assign vld_d = load_i | (vld_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_o.valid        = vld_q;
  assign out_o.found        = res_q.found;
  assign out_o.value_offset = res_q.value_offset;
  assign out_o.value_length = res_q.value_length;
  assign out_o.overflow     = res_q.overflow;

endmodule

/* sim/tb_json_key_value_locator.sv */
// ----------------------------------------------------------------------------
// tb_json_key_value_locator
// streams json documents into the locator under random stalls on both
// channels, predicts each document result in the bench and compares every
// located value field by field; directed documents first, then random ones
// ----------------------------------------------------------------------------
module tb_json_key_value_locator;
  import jkvl_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_index;
  logic [CfgBits-1:0]  cfg_wdata;

  jkvl_in_if  doc_if ();
  jkvl_out_if loc_if ();

  json_key_value_locator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (doc_if),
    .out_o       (loc_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // bench copy of the configuration and of the parser state
  logic [63:0] key_text_cfg;
  klen_t       key_len_cfg;
  phase_e      doc_phase;
  int unsigned key_pos;
  pos_t        doc_pos;
  int unsigned depth;
  logic        in_str;
  logic        esc;
  pos_t        val_start;
  pos_t        val_end;
  logic        sat;

  res_t        located_q[$];
  logic [7:0]  doc_q[$];
  int          mismatches  = 0;
  int          quiet_cycles = 0;
  logic        src_gaps = 1'b1;
  logic        calm     = 1'b0;

  function automatic logic blank_char(logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

  function automatic void clear_doc();
    doc_phase = PH_SEARCH;
    key_pos   = 0;
    doc_pos   = '0;
    depth     = 0;
    in_str    = 1'b0;
    esc       = 1'b0;
    val_start = '0;
    val_end   = '0;
    sat       = 1'b0;
  endfunction

  function automatic void note_content(logic [7:0] b, pos_t pos);
    if (!blank_char(b)) begin
      if (pos == PosMax) begin
        val_end = PosMax;
        sat     = 1'b1;
      end else begin
        val_end = pos + 16'd1;
      end
    end
  endfunction

  function automatic void scan_value(logic [7:0] b, pos_t pos);
    logic ended;
    ended = 1'b0;
    if (in_str) begin
      if (esc) esc = 1'b0;
      else if (b == ChBslash) esc = 1'b1;
      else if (b == ChQuote) in_str = 1'b0;
    end else if (b == ChQuote) begin
      in_str = 1'b1;
    end else if (b == ChLBrace || b == ChLBrack) begin
      if (depth >= MaxDepth) sat = 1'b1;
      else depth++;
    end else if (b == ChRBrace || b == ChRBrack) begin
      if (depth == 0) ended = 1'b1;
      else depth--;
    end else if (b == ChComma && depth == 0) begin
      ended = 1'b1;
    end
    if (ended) doc_phase = PH_DONE;
    else note_content(b, pos);
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned klen;
    pos_t        pos;
    klen = (key_len_cfg > KeyLenLimit) ? KeyLenLimit : key_len_cfg;
    pos  = doc_pos;
    case (doc_phase)
      PH_SEARCH: begin
        if (b == ChQuote) begin
          doc_phase = PH_MATCH;
          key_pos   = 0;
        end
      end
      PH_MATCH: begin
        // a quote that breaks a partial match opens a fresh candidate
        if (b == ChQuote) begin
          if (key_pos == klen) doc_phase = PH_COLON;
          else key_pos = 0;
        end else if (key_pos < klen && b == key_text_cfg[8*key_pos +: 8]) begin
          key_pos++;
        end else begin
          doc_phase = PH_SEARCH;
        end
      end
      PH_COLON: begin
        if (!blank_char(b)) begin
          if (b == ChColon) begin
            doc_phase = PH_LEAD;
          end else if (b == ChQuote) begin
            doc_phase = PH_MATCH;
            key_pos   = 0;
          end else begin
            doc_phase = PH_SEARCH;
          end
        end
      end
      PH_LEAD: begin
        if (!blank_char(b)) begin
          val_start = pos;
          val_end   = pos;
          doc_phase = PH_SCAN;
          scan_value(b, pos);
        end
      end
      PH_SCAN: scan_value(b, pos);
      default: ;
    endcase
    if (doc_pos == PosMax) sat = 1'b1;
    else doc_pos++;
  endfunction

  function automatic res_t located_now();
    res_t r;
    pos_t s;
    pos_t e;
    s = '0;
    e = '0;
    r.found = doc_phase inside {PH_LEAD, PH_SCAN, PH_DONE};
    if (doc_phase == PH_LEAD) begin
      s = doc_pos;
      e = doc_pos;
    end else if (r.found) begin
      s = val_start;
      e = val_end;
    end
    r.value_offset = s;
    r.value_length = (e >= s) ? e - s : '0;
    r.overflow     = sat;
    return r;
  endfunction

  // returns 1 when the byte closes a document and r holds its result
  function automatic logic locate_step(input logic [7:0] b, input logic last, output res_t r);
    r = '0;
    if (doc_phase == PH_DRAIN) begin
      if (last) clear_doc();
      return 1'b0;
    end
    if (b == ChNul) begin
      r = located_now();
      clear_doc();
      if (!last) doc_phase = PH_DRAIN;
      return 1'b1;
    end
    take_byte(b);
    if (last) begin
      r = located_now();
      clear_doc();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic push_byte(input logic [7:0] b, input logic last);
    res_t r;
    if (!calm && src_gaps && $urandom_range(0, 7) == 0) begin
      doc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    doc_if.valid      <= 1'b1;
    doc_if.byte_value <= b;
    doc_if.last_byte  <= last;
    do @(posedge clk_i); while (!doc_if.ready);
    if (locate_step(b, last, r)) located_q.push_back(r);
  endtask

  task automatic send_doc();
    int n;
    n = doc_q.size();
    for (int i = 0; i < n; i++) push_byte(doc_q[i], i == n - 1);
  endtask

  task automatic pause_until_drained();
    doc_if.valid <= 1'b0;
    do @(posedge clk_i); while (located_q.size() != 0);
  endtask

  task automatic set_key(input logic [63:0] text, input klen_t len);
    logic [63:0] upper;
    upper = {$urandom, $urandom};
    pause_until_drained();
    // drain bytes may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CfgKeyText;
    cfg_wdata <= text;
    @(posedge clk_i);
    key_text_cfg = text;
    cfg_index <= CfgKeyLength;
    cfg_wdata <= {upper[63:KeyLenBits], len};
    @(posedge clk_i);
    key_len_cfg = len;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_located
    res_t want;
    if (rst_ni && loc_if.valid && loc_if.ready) begin
      if (located_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result actual found=%0b offset=%0d length=%0d overflow=%0b",
                 $time, loc_if.found, loc_if.value_offset, loc_if.value_length,
                 loc_if.overflow);
      end else begin
        want = located_q.pop_front();
        if (loc_if.found !== want.found) begin
          mismatches++;
          $display("%0t: found expected %0b actual %0b", $time, want.found, loc_if.found);
        end
        if (loc_if.value_offset !== want.value_offset) begin
          mismatches++;
          $display("%0t: value_offset expected %0d actual %0d", $time,
                   want.value_offset, loc_if.value_offset);
        end
        if (loc_if.value_length !== want.value_length) begin
          mismatches++;
          $display("%0t: value_length expected %0d actual %0d", $time,
                   want.value_length, loc_if.value_length);
        end
        if (loc_if.overflow !== want.overflow) begin
          mismatches++;
          $display("%0t: overflow expected %0b actual %0b", $time,
                   want.overflow, loc_if.overflow);
        end
      end
    end
  end

  // result side: random stall bursts with stretches of steady ready
  initial begin
    loc_if.ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        loc_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      loc_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((doc_if.valid && doc_if.ready) || (loc_if.valid && loc_if.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("json_key_value_locator regression: fail");
    $finish;
  end

  // ------------------------------------------------------ document building

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [63:0] pack_key(string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  function automatic logic [63:0] make_key(int n);
    logic [63:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < n && i < 8; i++) k[8*i +: 8] = rand_letter();
    return k;
  endfunction

  function automatic void put_str(string s);
    foreach (s[i]) doc_q.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: doc_q.push_back(ChSpace);
        1: doc_q.push_back(ChTab);
        2: doc_q.push_back(ChCr);
        default: doc_q.push_back(ChLf);
      endcase
    end
  endfunction

  function automatic void put_key_name(logic hit);
    int unsigned klen;
    int unsigned n;
    klen = (key_len_cfg > KeyLenLimit) ? KeyLenLimit : key_len_cfg;
    doc_q.push_back(ChQuote);
    if (hit) begin
      for (int i = 0; i < klen; i++) doc_q.push_back(key_text_cfg[8*i +: 8]);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          n = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
          for (int i = 0; i < n; i++) doc_q.push_back(key_text_cfg[8*i +: 8]);
          doc_q.push_back(rand_letter());
        end
        1: begin
          for (int i = 0; i < klen; i++) doc_q.push_back(key_text_cfg[8*i +: 8]);
          doc_q.push_back(rand_letter());
        end
        default: repeat ($urandom_range(1, 4)) doc_q.push_back(rand_letter());
      endcase
    end
    doc_q.push_back(ChQuote);
  endfunction

  function automatic void put_value(int lvl);
    int n;
    case ($urandom_range(0, (lvl > 0) ? 5 : 2))
      1: begin
        doc_q.push_back(ChQuote);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: put_str("\\\"");
            1: put_str("\\\\");
            2: doc_q.push_back(ChLBrace);
            3: doc_q.push_back(ChComma);
            4: doc_q.push_back(ChRBrack);
            default: doc_q.push_back(rand_letter());
          endcase
        end
        doc_q.push_back(ChQuote);
      end
      2: put_str(($urandom_range(0, 1) != 0) ? "true" : "null");
      3: begin
        doc_q.push_back(ChLBrace);
        put_ws();
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc_q.push_back(ChComma);
          put_key_name($urandom_range(0, 2) == 0);
          put_ws();
          doc_q.push_back(ChColon);
          put_ws();
          put_value(lvl - 1);
          put_ws();
        end
        doc_q.push_back(ChRBrace);
      end
      4: begin
        doc_q.push_back(ChLBrack);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc_q.push_back(ChComma);
          put_ws();
          put_value(lvl - 1);
        end
        doc_q.push_back(ChRBrack);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) put_str("-");
        repeat ($urandom_range(1, 4)) doc_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
    endcase
  endfunction

  function automatic void put_object();
    int pairs;
    int hit_at;
    put_ws();
    doc_q.push_back(ChLBrace);
    put_ws();
    pairs  = $urandom_range(1, 4);
    hit_at = ($urandom_range(0, 4) != 0) ? $urandom_range(0, pairs - 1) : -1;
    for (int i = 0; i < pairs; i++) begin
      if (i > 0) begin
        doc_q.push_back(ChComma);
        put_ws();
      end
      put_key_name(i == hit_at);
      put_ws();
      doc_q.push_back(ChColon);
      put_ws();
      put_value(2);
      put_ws();
    end
    doc_q.push_back(ChRBrace);
    put_ws();
  endfunction

  function automatic void build_document();
    int kind;
    int n;
    doc_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 17) begin
      repeat ($urandom_range(1, 16)) doc_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_object();
      n = doc_q.size();
      if (kind >= 14 && kind <= 16) begin
        // broken: keep only a random leading part of the document
        doc_q = doc_q[0:$urandom_range(0, n - 1)];
      end else if (kind == 18) begin
        doc_q[$urandom_range(0, n - 1)] = ChNul;
      end else if (kind == 19) begin
        repeat ($urandom_range(1, 3)) doc_q[$urandom_range(0, n - 1)] = 8'($urandom_range(1, 255));
      end
    end
  endfunction

  task automatic send_text(string s);
    doc_q.delete();
    put_str(s);
    send_doc();
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_reset_config();
    // key registers still hold their reset value: the empty key
    send_text("{\"\":5}");
    send_text("{\"a\":1,\"\":[2]}");
  endtask

  task automatic test_lookup();
    set_key(pack_key("name"), 4'd4);
    send_text("{\"name\":\"a\\\"b,}\" ,\"x\":1}");
    send_text("{ \"id\" : 3 , \"name\"  :  {\"a\":[1,{\"b\":2}],\"c\":\"}\"}  }");
    send_text("[\"name\",{\"name\"\t:\r\n-12.5e3 \n}]");
    send_text("{\"x\":{\"name\":true},\"name\":0}");
  endtask

  task automatic test_search_restart();
    send_text("{\"nam\"name\":1}");
    send_text("{\"nname\":1,\"name\":2}");
    send_text("{\"name\"x:1,\"name\" \"name\":3}");
    send_text("\"name\"");
    send_text("{\"na\":1}");
  endtask

  task automatic test_missing_value();
    send_text("{\"name\":");
    send_text("{\"name\": \t\r\n");
    send_text("{\"name\":}");
    send_text("{\"name\" :,");
  endtask

  task automatic test_zero_byte();
    doc_q.delete();
    put_str("{\"name\":12");
    doc_q.push_back(ChNul);
    put_str("tail\"name\":9");
    send_doc();
    // zero carrying last ends the discard stretch
    doc_q.delete();
    put_str("{\"name\": 4");
    doc_q.push_back(ChNul);
    put_str("xyz");
    doc_q.push_back(ChNul);
    send_doc();
    doc_q.delete();
    put_str("{\"name\":1");
    doc_q.push_back(ChNul);
    send_doc();
    push_byte(ChNul, 1'b1);
    push_byte(ChNul, 1'b0);
    push_byte(8'h61, 1'b1);
  endtask

  task automatic test_quote_in_key();
    set_key(pack_key("a\"b"), 4'd3);
    send_text("{\"a\"b\":1}");
    send_text("{\"a\\\"b\":1}");
  endtask

  task automatic test_long_key_length();
    set_key(pack_key("longkey8"), 4'd15);
    send_text("{\"longkey8\":[1,2]}");
    send_text("{\"longkey8x\":1}");
    set_key(pack_key("longkey8"), 4'd9);
    send_text("{\"longkey8\" : 7 }");
  endtask

  task automatic test_depth_saturation();
    set_key(pack_key("d"), 4'd1);
    doc_q.delete();
    put_str("{\"d\":");
    repeat (258) doc_q.push_back(ChLBrack);
    put_str("1");
    repeat (258) doc_q.push_back(ChRBrack);
    put_str("}");
    send_doc();
  endtask

  task automatic test_random_documents();
    logic [63:0] text;
    klen_t       len;
    int          sent;
    int          docs;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: len = 4'd2;
        1: len = 4'd0;
        2: len = 4'd8;
        3: len = 4'd1;
        4: len = 4'd12;
        5: len = 4'd8;
        default: len = klen_t'($urandom_range(3, 5));
      endcase
      text = (p == 5) ? '1 : make_key(len);
      if (p == 6) calm = 1'b1;
      set_key(text, len);
      sent = 0;
      docs = 0;
      while (sent < PHASE_BYTES) begin
        src_gaps = ($urandom_range(0, 3) != 0);
        if (docs == 1 || $urandom_range(0, 24) == 0) pause_until_drained();
        build_document();
        send_doc();
        sent += doc_q.size();
        docs++;
      end
    end
  endtask

  task automatic finish_run();
    pause_until_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (mismatches == 0 && located_q.size() == 0) begin
      $display("json_key_value_locator regression: pass");
    end else begin
      $display("json_key_value_locator regression: fail");
    end
    $finish;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CfgKeyText;
    cfg_wdata         <= '0;
    doc_if.valid      <= 1'b0;
    doc_if.byte_value <= '0;
    doc_if.last_byte  <= 1'b0;
    key_text_cfg = '0;
    key_len_cfg  = '0;
    clear_doc();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_lookup();
    test_search_restart();
    test_missing_value();
    test_zero_byte();
    test_quote_in_key();
    test_long_key_length();
    test_depth_saturation();
    test_random_documents();
    finish_run();
  end

endmodule

/* files.f */
+incdir+design
design/jkvl_pkg.sv
design/jkvl_if.sv
design/jkvl_parser.sv
design/jkvl_out_reg.sv
design/json_key_value_locator.sv
sim/tb_json_key_value_locator.sv
